/* rtl/tftp_rx_pkg.sv */
// Shared types and constants for the TFTP read-transfer receive controller.
// No dependencies; every other file in rtl imports this package.
package tftp_rx_pkg;

  localparam int BLOCK_SIZE = 512;
  localparam int BLK_SHIFT  = $clog2(BLOCK_SIZE);
  localparam int BLK_W      = 16;
  localparam int LEN_W      = 10;
  localparam int OFF_W      = BLK_W + BLK_SHIFT;
  localparam int ADDR_W     = 32;
  localparam int FSIZE_W    = 25;
  localparam int RETRY_W    = 8;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [15:0] OPC_DATA = 16'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_ADDRESS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd2;

  localparam logic [ADDR_W-1:0]  LOAD_ADDRESS_RST  = 32'd0;
  localparam logic [RETRY_W-1:0] MAX_RETRIES_RST   = 8'd5;
  localparam logic [TICK_W-1:0]  TIMEOUT_TICKS_RST = 16'd5000;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_PACKET = 2'd1,
    OP_TICK   = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_RRQ    = 3'd1,
    PH_ACK    = 3'd2,
    PH_DONE   = 3'd3,
    PH_FAILED = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_DATA    = 3'd1,
    ST_BAD_BLOCK   = 3'd2,
    ST_NOT_ACTIVE  = 3'd3,
    ST_RETRY_LIMIT = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    CMD_START,
    CMD_DATA,
    CMD_OTHER_PKT,
    CMD_TICK,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [BLK_W-1:0]   blk;
    logic [OFF_W-1:0]   off;
    logic [LEN_W-1:0]   len;
    logic               last;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  load_address;
    logic [RETRY_W-1:0] max_retries;
    logic [TICK_W-1:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               rrq_send;
    logic               ack_send;
    logic [BLK_W-1:0]   ack_block;
    logic               write_enable;
    logic [ADDR_W-1:0]  write_address;
    logic [LEN_W-1:0]   write_length;
    logic               done_res;
    logic               failed;
    logic [FSIZE_W-1:0] rx_bytes;
    status_t            status;
  } res_t;

endpackage

/* rtl/tftp_rx_in_if.sv */
// Input channel: start commands, packet headers and millisecond ticks.
// Depends on tftp_rx_pkg for field widths.
interface tftp_rx_in_if
  import tftp_rx_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [1:0]        op;
  logic [15:0]       pkt_opcode;
  logic [BLK_W-1:0]  pkt_block;
  logic [LEN_W-1:0]  payload_length;

  modport source (output valid, op, pkt_opcode, pkt_block, payload_length, input ready);
  modport sink   (input valid, op, pkt_opcode, pkt_block, payload_length, output ready);
endinterface

/* rtl/tftp_rx_out_if.sv */
// Result channel: send requests, payload store commands and transfer status.
// Depends on tftp_rx_pkg for field widths.
interface tftp_rx_out_if
  import tftp_rx_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               rrq_send;
  logic               ack_send;
  logic [BLK_W-1:0]   ack_block;
  logic               write_enable;
  logic [ADDR_W-1:0]  write_address;
  logic [LEN_W-1:0]   write_length;
  logic               done_res;
  logic               failed;
  logic [FSIZE_W-1:0] rx_bytes;
  logic [2:0]         status;

  modport source (output valid, rrq_send, ack_send, ack_block, write_enable, write_address,
                  write_length, done_res, failed, rx_bytes, status, input ready);
  modport sink   (input valid, rrq_send, ack_send, ack_block, write_enable, write_address,
                  write_length, done_res, failed, rx_bytes, status, output ready);
endinterface

/* rtl/tftp_rx_front.sv */
// Front end: accepts input beats and classifies them into queue commands.
// Depends on tftp_rx_pkg and tftp_rx_in_if.
module tftp_rx_front
  import tftp_rx_pkg::*;
(
  tftp_rx_in_if.sink cmd,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_data
);

  logic [BLK_W-1:0] idx;
  logic [LEN_W-1:0] len_clamped;

  assign cmd.ready = !q_full;
  assign q_push    = cmd.valid && !q_full;
  assign idx       = cmd.pkt_block - 16'd1;

  always_comb begin
    if (32'(cmd.payload_length) > 32'(BLOCK_SIZE)) begin
      len_clamped = LEN_W'(BLOCK_SIZE);
    end else begin
      len_clamped = cmd.payload_length;
    end
  end

  always_comb begin
    q_data.blk  = cmd.pkt_block;
    q_data.off  = {idx, {BLK_SHIFT{1'b0}}};
    q_data.len  = len_clamped;
    q_data.last = 32'(len_clamped) < 32'(BLOCK_SIZE);
    unique case (op_t'(cmd.op))
      OP_START:  q_data.kind = CMD_START;
      OP_PACKET: q_data.kind = (cmd.pkt_opcode == OPC_DATA) ? CMD_DATA : CMD_OTHER_PKT;
      OP_TICK:   q_data.kind = CMD_TICK;
      OP_UNUSED: q_data.kind = CMD_NOP;
    endcase
  end

endmodule

/* rtl/tftp_rx_queue.sv */
// Short command queue between the front end and the transfer engine.
// Depends on tftp_rx_pkg for the command type and depth.
module tftp_rx_queue
  import tftp_rx_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;

  assign full       = count == (FIFO_AW+1)'(FIFO_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/tftp_rx_back.sv */
// Transfer engine: holds the transfer state and registers one result per command.
// Depends on tftp_rx_pkg and tftp_rx_out_if.
module tftp_rx_back
  import tftp_rx_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           head_valid,
  input  cmd_t           head,
  output logic           pop,
  tftp_rx_out_if.source  res
);

  phase_t             phase;
  phase_t             phase_next;
  logic [BLK_W-1:0]   expected_block;
  logic [BLK_W-1:0]   expected_block_next;
  logic [RETRY_W-1:0] retry_count;
  logic [RETRY_W-1:0] retry_count_next;
  logic [TICK_W-1:0]  elapsed_ticks;
  logic [TICK_W-1:0]  elapsed_ticks_next;
  res_t               r;
  logic               take;
  logic               active;
  logic               blk_ok;
  logic               timeout;
  logic               exhausted;

  assign take      = head_valid && (!res.valid || res.ready);
  assign pop       = take;
  assign active    = (phase == PH_RRQ) || (phase == PH_ACK);
  assign blk_ok    = head.blk == (expected_block + 16'd1);
  assign timeout   = elapsed_ticks >= cfg.timeout_ticks;
  assign exhausted = retry_count >= cfg.max_retries;

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (head.kind)
        CMD_START: phase_next = PH_RRQ;
        CMD_DATA: begin
          if (active && blk_ok) begin
            phase_next = head.last ? PH_DONE : PH_ACK;
          end
        end
        CMD_TICK: begin
          if (active && timeout && exhausted) begin
            phase_next = PH_FAILED;
          end
        end
        CMD_OTHER_PKT, CMD_NOP: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    r                   = '0;
    r.status            = ST_OK;
    expected_block_next = expected_block;
    retry_count_next    = retry_count;
    elapsed_ticks_next  = elapsed_ticks;
    unique case (head.kind)
      CMD_START: begin
        expected_block_next = '0;
        retry_count_next    = '0;
        elapsed_ticks_next  = '0;
        r.rrq_send          = 1'b1;
      end
      CMD_OTHER_PKT: begin
        r.status = active ? ST_NOT_DATA : ST_NOT_ACTIVE;
      end
      CMD_DATA: begin
        if (!active) begin
          r.status = ST_NOT_ACTIVE;
        end else if (!blk_ok) begin
          r.status = ST_BAD_BLOCK;
        end else begin
          r.write_enable      = 1'b1;
          r.write_address     = cfg.load_address + ADDR_W'(head.off);
          r.write_length      = head.len;
          r.ack_send          = 1'b1;
          r.ack_block         = head.blk;
          expected_block_next = head.blk;
          elapsed_ticks_next  = '0;
          if (head.last) begin
            r.done_res = 1'b1;
            r.rx_bytes = FSIZE_W'(32'(head.off) + 32'(head.len));
          end
        end
      end
      CMD_TICK: begin
        if (!active) begin
          r.status = ST_NOT_ACTIVE;
        end else if (timeout) begin
          elapsed_ticks_next = '0;
          if (exhausted) begin
            r.failed = 1'b1;
            r.status = ST_RETRY_LIMIT;
          end else begin
            retry_count_next = retry_count + 1'b1;
            if (phase == PH_RRQ) begin
              r.rrq_send = 1'b1;
            end else begin
              r.ack_send  = 1'b1;
              r.ack_block = expected_block;
            end
          end
        end else begin
          elapsed_ticks_next = elapsed_ticks + 1'b1;
        end
      end
      CMD_NOP: r.status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      expected_block <= '0;
      retry_count    <= '0;
      elapsed_ticks  <= '0;
      res.valid      <= 1'b0;
    end else begin
      phase <= phase_next;
      if (take) begin
        expected_block <= expected_block_next;
        retry_count    <= retry_count_next;
        elapsed_ticks  <= elapsed_ticks_next;
        res.valid      <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res.rrq_send      <= r.rrq_send;
      res.ack_send      <= r.ack_send;
      res.ack_block     <= r.ack_block;
      res.write_enable  <= r.write_enable;
      res.write_address <= r.write_address;
      res.write_length  <= r.write_length;
      res.done_res      <= r.done_res;
      res.failed        <= r.failed;
      res.rx_bytes      <= r.rx_bytes;
      res.status        <= r.status;
    end
  end

endmodule

/* rtl/tftp_receive_controller.sv */
// Channel  | Dir | Beat contents
// cmd      | in  | op, pkt_opcode, pkt_block, payload_length
// res      | out | send requests, store address and length, done, failed, size, status
// cfg      | in  | write enable, register index, 32-bit write data
//
// One result per input beat; a beat that finds the queue and output register free
// passes through a queue entry and then the output register before it is offered on
// res, and one beat per cycle is sustained while res is ready.
// The four-entry command queue absorbs stalls on res before cmd ready drops.
// Reset is synchronous and clears the queue, transfer state and registers to defaults.
// Top level of the TFTP read-transfer receive controller.
// Depends on tftp_rx_pkg, both channel interfaces, front, queue and back.
module tftp_receive_controller
  import tftp_rx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  tftp_rx_in_if.sink            cmd,
  tftp_rx_out_if.source         res
);

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_data;
  logic q_pop;
  logic head_valid;
  cmd_t head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.load_address  <= LOAD_ADDRESS_RST;
      cfg.max_retries   <= MAX_RETRIES_RST;
      cfg.timeout_ticks <= TIMEOUT_TICKS_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_LOAD_ADDRESS) begin
        cfg.load_address <= cfg_data;
      end
      if (cfg_index == CFG_MAX_RETRIES) begin
        cfg.max_retries <= cfg_data[RETRY_W-1:0];
      end
      if (cfg_index == CFG_TIMEOUT_TICKS) begin
        cfg.timeout_ticks <= cfg_data[TICK_W-1:0];
      end
    end
  end

  tftp_rx_front u_front (
    .cmd    (cmd),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_data)
  );

  tftp_rx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tftp_rx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (q_pop),
    .res        (res)
  );

endmodule

/* sim/tb.sv */
// Testbench for tftp_receive_controller: directed and random command beats, checked
// against an in-bench model of the read-transfer state machine, with random stalls.
// Depends on tftp_rx_pkg, tftp_rx_in_if, tftp_rx_out_if and the controller RTL.
module tb
  import tftp_rx_pkg::*;
;

  localparam int QUIET_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tftp_rx_in_if cmd_if ();
  tftp_rx_out_if res_if ();

  tftp_receive_controller dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_if),
    .res       (res_if)
  );

  always #5 clk = ~clk;

  // Shadow of the transfer state and the registers.
  phase_t ph;
  logic [BLK_W-1:0] exp_blk;
  logic [RETRY_W-1:0] retries;
  logic [TICK_W-1:0] elapsed;
  logic [ADDR_W-1:0] load_addr_reg;
  logic [RETRY_W-1:0] max_retries_reg;
  logic [TICK_W-1:0] timeout_reg;

  res_t pending_responses[$];

  int mismatch_count = 0;
  int beats_sent = 0;
  int responses_seen = 0;
  int transfers_done = 0;
  int transfers_failed = 0;
  int quiet_cycles = 0;

  int gap_max = 0;
  int burst_left = 0;
  int stall_pct = 0;
  int hold_cycles_req = 0;
  int hold_left = 0;

  task automatic predict_transfer_step(input op_t op, input logic [15:0] opc,
                                       input logic [BLK_W-1:0] blk,
                                       input logic [LEN_W-1:0] len);
    res_t r;
    logic [BLK_W-1:0] idx;
    logic [ADDR_W-1:0] off;
    logic [LEN_W-1:0] n;
    logic active;
    r = '0;
    r.status = ST_OK;
    active = (ph == PH_RRQ) || (ph == PH_ACK);
    case (op)
      OP_START: begin
        exp_blk = '0;
        retries = '0;
        elapsed = '0;
        ph = PH_RRQ;
        r.rrq_send = 1'b1;
      end
      OP_PACKET: begin
        if (!active) begin
          r.status = ST_NOT_ACTIVE;
        end else if (opc != OPC_DATA) begin
          r.status = ST_NOT_DATA;
        end else if (blk != exp_blk + 16'd1) begin
          r.status = ST_BAD_BLOCK;
        end else begin
          idx = blk - 16'd1;
          off = ADDR_W'(idx) * ADDR_W'(BLOCK_SIZE);
          n = (len > BLOCK_SIZE) ? LEN_W'(BLOCK_SIZE) : len;
          r.write_enable = 1'b1;
          r.write_address = load_addr_reg + off;
          r.write_length = n;
          r.ack_send = 1'b1;
          r.ack_block = blk;
          exp_blk = blk;
          elapsed = '0;
          if (n < BLOCK_SIZE) begin
            r.done_res = 1'b1;
            r.rx_bytes = FSIZE_W'(off + ADDR_W'(n));
            ph = PH_DONE;
            transfers_done++;
          end else begin
            ph = PH_ACK;
          end
        end
      end
      OP_TICK: begin
        if (!active) begin
          r.status = ST_NOT_ACTIVE;
        end else if (elapsed >= timeout_reg) begin
          elapsed = '0;
          if (retries >= max_retries_reg) begin
            ph = PH_FAILED;
            r.failed = 1'b1;
            r.status = ST_RETRY_LIMIT;
            transfers_failed++;
          end else begin
            retries = retries + 8'd1;
            if (ph == PH_RRQ) begin
              r.rrq_send = 1'b1;
            end else begin
              r.ack_send = 1'b1;
              r.ack_block = exp_blk;
            end
          end
        end else begin
          elapsed = elapsed + 16'd1;
        end
      end
      default: ;
    endcase
    pending_responses.push_back(r);
  endtask

  task automatic send_beat(input op_t op, input logic [15:0] opc,
                           input logic [BLK_W-1:0] blk, input logic [LEN_W-1:0] len);
    int gap;
    if (gap_max > 0 && burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      repeat (gap) begin
        @(negedge clk);
        cmd_if.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    cmd_if.valid <= 1'b1;
    cmd_if.op <= op;
    cmd_if.pkt_opcode <= opc;
    cmd_if.pkt_block <= blk;
    cmd_if.payload_length <= len;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predict_transfer_step(op, opc, blk, len);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_LOAD_ADDRESS: load_addr_reg = data;
      CFG_MAX_RETRIES: max_retries_reg = data[RETRY_W-1:0];
      CFG_TIMEOUT_TICKS: timeout_reg = data[TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [ADDR_W-1:0] load, input logic [RETRY_W-1:0] retry_max,
                           input logic [TICK_W-1:0] ticks);
    write_reg(CFG_LOAD_ADDRESS, load);
    write_reg(CFG_MAX_RETRIES, {24'($urandom), retry_max});
    write_reg(CFG_TIMEOUT_TICKS, {16'($urandom), ticks});
  endtask

  // Stops offering beats and waits until every expected response has come back.
  task automatic settle();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random_beat();
    int pick;
    logic [BLK_W-1:0] blk;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(99);
    len = LEN_W'($urandom);
    blk = 16'($urandom);
    if (ph != PH_RRQ && ph != PH_ACK) begin
      if (pick < 70) send_beat(OP_START, 16'($urandom), blk, len);
      else if (pick < 80) send_beat(OP_TICK, 16'($urandom), blk, len);
      else if (pick < 92) send_beat(OP_PACKET, ($urandom_range(1) ? OPC_DATA : 16'($urandom)),
                                    blk, len);
      else send_beat(OP_UNUSED, 16'($urandom), blk, len);
    end else if (pick < 50) begin
      case ($urandom_range(9))
        0, 1: len = LEN_W'($urandom_range(0, BLOCK_SIZE - 1));
        9: len = LEN_W'($urandom_range(BLOCK_SIZE + 1, (1 << LEN_W) - 1));
        default: len = LEN_W'(BLOCK_SIZE);
      endcase
      send_beat(OP_PACKET, OPC_DATA, exp_blk + 16'd1, len);
    end else if (pick < 78) begin
      send_beat(OP_TICK, 16'($urandom), blk, len);
    end else if (pick < 86) begin
      if ($urandom_range(1)) blk = exp_blk;
      send_beat(OP_PACKET, OPC_DATA, blk, len);
    end else if (pick < 93) begin
      send_beat(OP_PACKET, 16'($urandom), exp_blk + 16'd1, len);
    end else if (pick < 97) begin
      send_beat(OP_START, 16'($urandom), blk, len);
    end else begin
      send_beat(OP_UNUSED, 16'($urandom), blk, len);
    end
  endtask

  task automatic test_basic_sequence();
    send_beat(OP_PACKET, OPC_DATA, 16'd1, 10'd512);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_UNUSED, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_beat(OP_START, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_PACKET, 16'hFFFF, 16'd1, 10'd512);
    send_beat(OP_PACKET, OPC_DATA, 16'd0, 10'd512);
    send_beat(OP_PACKET, OPC_DATA, 16'hFFFF, 10'd512);
    send_beat(OP_PACKET, OPC_DATA, 16'd1, 10'd512);
    send_beat(OP_PACKET, OPC_DATA, 16'd2, 10'h3FF);
    send_beat(OP_PACKET, OPC_DATA, 16'd2, 10'd100);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_PACKET, OPC_DATA, 16'd3, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_PACKET, OPC_DATA, 16'd4, 10'd512);
    send_beat(OP_START, 16'hFFFF, 16'hFFFF, 10'h3FF);
    send_beat(OP_PACKET, OPC_DATA, 16'd1, 10'd511);
  endtask

  task automatic test_timeouts();
    settle();
    configure(32'h0000_1000, 8'd0, 16'd0);
    send_beat(OP_START, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    settle();
    configure(32'h0000_1000, 8'd1, 16'd1);
    send_beat(OP_START, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_PACKET, OPC_DATA, 16'd1, 10'd512);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
    send_beat(OP_TICK, 16'h0000, 16'h0000, 10'd0);
  endtask

  task automatic test_backpressure();
    settle();
    configure(32'h8000_0000, 8'd3, 16'd2);
    stall_pct = 0;
    gap_max = 0;
    hold_cycles_req = 80;
    repeat (30) send_random_beat();
    settle();
  endtask

  task automatic test_random_transfers();
    for (int s = 0; s < 6; s++) begin
      settle();
      case (s)
        0: configure(32'h0000_0000, 8'd0, 16'd0);
        1: configure(32'hFFFF_FFFF, 8'd255, 16'd65535);
        2: configure(32'hFFFF_FE00, 8'($urandom_range(0, 4)), 16'($urandom_range(1, 6)));
        default: configure($urandom, 8'($urandom_range(0, 4)), 16'($urandom_range(1, 6)));
      endcase
      stall_pct = (s % 3) * 30;
      gap_max = (s == 3) ? 0 : $urandom_range(2, 6);
      repeat (65) send_random_beat();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      responses_seen++;
      if (pending_responses.size() == 0) begin
        $display("%0t: response beat with nothing expected, actual status %0h",
                 $time, res_if.status);
        mismatch_count++;
      end else begin
        want = pending_responses.pop_front();
        check_field("rrq_send", want.rrq_send, res_if.rrq_send);
        check_field("ack_send", want.ack_send, res_if.ack_send);
        check_field("ack_block", want.ack_block, res_if.ack_block);
        check_field("write_enable", want.write_enable, res_if.write_enable);
        check_field("write_address", want.write_address, res_if.write_address);
        check_field("write_length", want.write_length, res_if.write_length);
        check_field("done_res", want.done_res, res_if.done_res);
        check_field("failed", want.failed, res_if.failed);
        check_field("rx_bytes", want.rx_bytes, res_if.rx_bytes);
        check_field("status", want.status, res_if.status);
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles_req > 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d responses outstanding",
               $time, quiet_cycles, pending_responses.size());
      $display("tftp_receive_controller: mismatch");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_if.valid = 1'b0;
    cmd_if.op = OP_START;
    cmd_if.pkt_opcode = '0;
    cmd_if.pkt_block = '0;
    cmd_if.payload_length = '0;
    res_if.ready = 1'b0;
    ph = PH_IDLE;
    exp_blk = '0;
    retries = '0;
    elapsed = '0;
    load_addr_reg = LOAD_ADDRESS_RST;
    max_retries_reg = MAX_RETRIES_RST;
    timeout_reg = TIMEOUT_TICKS_RST;
    stall_pct = 20;
    gap_max = 3;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_sequence();
    test_timeouts();
    test_backpressure();
    test_random_transfers();
    settle();

    $display("Sent %0d command beats and checked %0d response beats over several register values.",
             beats_sent, responses_seen);
    $display("Transfers completed: %0d, transfers failed on the retry limit: %0d.",
             transfers_done, transfers_failed);
    if (mismatch_count == 0 && pending_responses.size() == 0) begin
      $display("tftp_receive_controller: match");
    end else begin
      $display("tftp_receive_controller: mismatch");
    end
    $finish;
  end

endmodule
